/* src/double_ended_queue_macros.svh */
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// concurrent check, quiet while reset is held
`define DEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also runs through reset
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  localparam logic signed [WordW-1:0] EmptyWord = -32'sd1;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_op_e                  operation;
    logic signed [WordW-1:0]  value;
  } deq_cmd_t;

  typedef struct packed {
    logic signed [WordW-1:0]  front_value;
    logic signed [WordW-1:0]  back_value;
    logic [CountW-1:0]        entry_count;
    deq_status_e              status;
  } deq_result_t;

endpackage

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries. A command is taken when start is high and busy is low; its result
// appears on result_o in state S_OUT, reached through S_READ, marked by
// result_valid_o for exactly one cycle, and must be captured then since the
// receiver cannot stall. No command is taken in the read cycle: the accept
// cycle updates head and count and writes a pushed word into the ring memory,
// the next cycle reads both ends of the ring (registered read), and during the
// result cycle the next command may already be taken. busy is high only in the
// read cycle. Pops on an empty queue report status empty, pushes on a full
// queue report status full, and both ends read as -1 while the queue is empty.
module double_ended_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  deq_pkg::deq_cmd_t    cmd_i,
  output logic                 result_valid_o,
  output deq_pkg::deq_result_t result_o
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam int unsigned SumW = CntW + 1;

  logic [1:0]            state_q, state_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  deq_status_e           status_q, status_d;

  logic                  accept;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [IdxW-1:0]       head_inc, head_dec, tail_slot, back_slot;
  logic                  rd_en;

  logic [WordW-1:0]      ring_mem [DEPTH];
  logic [WordW-1:0]      rd_front_q, rd_back_q;

  function automatic logic [IdxW-1:0] slot_of(logic [IdxW-1:0] base, logic [CntW-1:0] ofs);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(ofs);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q == S_READ);

  assign head_inc  = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec  = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - 1'b1;
  assign tail_slot = slot_of(head_q, count_q);
  assign back_slot = slot_of(head_q, count_q - 1'b1);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = tail_slot;
    if (accept) begin
      status_d = ST_DONE;
      if (cmd_i.operation inside {OP_PUSH_FRONT, OP_PUSH_BACK}) begin
        if (count_q == CntW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (cmd_i.operation == OP_PUSH_FRONT) begin
            head_d  = head_dec;
            wr_addr = head_dec;
          end
        end
      end else begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          if (cmd_i.operation == OP_POP_FRONT) begin
            head_d = head_inc;
          end
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_READ : S_IDLE;
      S_READ:  state_d = S_OUT;
      S_OUT:   state_d = accept ? S_READ : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  // the write lands before both ends are read, so no bypass is needed
  assign rd_en = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_front_q <= ring_mem[head_q];
      rd_back_q  <= ring_mem[back_slot];
    end
  end

  assign result_valid_o       = (state_q == S_OUT);
  assign result_o.front_value = (count_q == '0) ? EmptyWord : rd_front_q;
  assign result_o.back_value  = (count_q == '0) ? EmptyWord : rd_back_q;
  assign result_o.entry_count = CountW'(count_q);
  assign result_o.status      = status_q;

endmodule

/* src/deq_checker.sv */
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 result_valid_o,
  input  deq_pkg::deq_result_t result_o
);
  import deq_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // every taken command is followed by its result strobe
  `DEQ_ASSERT(a_result_follows, clk_i, rst_ni, accept |-> ##2 result_valid_o, "result missing after accept")
  // a result strobe lasts one cycle only
  `DEQ_ASSERT(a_strobe_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result strobe held")
  // empty queue reports -1 at both ends
  `DEQ_ASSERT(a_empty_ends, clk_i, rst_ni,
    (result_valid_o && result_o.entry_count == '0) |->
    (result_o.front_value == EmptyWord && result_o.back_value == EmptyWord),
    "empty queue ends not -1")
  // a refused push only happens at full depth
  `DEQ_ASSERT(a_full_count, clk_i, rst_ni,
    (result_valid_o && result_o.status == ST_FULL) |-> (result_o.entry_count == CountW'(DEPTH)),
    "full status below depth")
  // every reset edge clears the strobe for the cycle after it
  `DEQ_ASSERT_ALWAYS(a_no_strobe_in_reset, clk_i, !rst_ni |=> !result_valid_o, "strobe during reset")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
